// ===== rtl/deq_pkg.sv =====
// Shared types, constants and ring arithmetic for the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue; depends on nothing.
`default_nettype none

package deq_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int FUNC_W      = 3;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_PEEK_FRONT = 3'd4,
      FN_PEEK_BACK  = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_LOAD
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } ctl_cmd_type;

   // Ring position of the word at offset off from the front; off is at most CAPACITY.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(off);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// Controller of the double-ended queue: sequences capture, execute and load
// of one item and owns the result valid flag. Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output deq_pkg::ctl_cmd_type      cmd
);
   import deq_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The output register may be refilled when it is empty or being taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_LOAD;
         end
         CTL_LOAD: begin
            if (out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         CTL_EXEC: begin
            cmd.execute = 1'b1;
         end
         CTL_LOAD: begin
            cmd.load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/deq_datapath.sv =====
// Datapath of the double-ended queue: slot memory, front pointer, word count,
// status logic and the result register. Depends on deq_pkg.
`default_nettype none

module deq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire deq_pkg::ctl_cmd_type              cmd,
   input  wire logic [deq_pkg::FUNC_W-1:0]        req_func,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   output logic signed [deq_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [deq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [deq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic                                   rsp_is_empty
);
   import deq_pkg::*;

   logic [WORD_W-1:0]      slots [CAPACITY];

   logic [FUNC_W-1:0]      func_ff;
   logic [WORD_W-1:0]      value_ff;
   logic [IDX_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rd_ok_ff, rd_ok_in;
   status_type             status_ff, status_in;

   logic [WORD_W-1:0]      rsp_value_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       front_prev, front_next, back_pos, tail_pos;
   logic                   is_full, is_empty;

   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign front_prev = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_next = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;
   assign back_pos   = ring_add(front_ff, count_ff - 1'b1);
   assign tail_pos   = ring_add(front_ff, count_ff);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_pos;
      rd_addr   = front_ff;
      rd_ok_in  = 1'b0;
      status_in = ST_OK;
      case (func_ff)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (func_ff == FN_PUSH_FRONT) begin
                  wr_addr  = front_prev;
                  front_in = front_prev;
               end
            end
         end
         FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_ok_in = 1'b1;
               if (func_ff == FN_POP_BACK || func_ff == FN_PEEK_BACK) begin
                  rd_addr = back_pos;
               end
               if (func_ff == FN_POP_FRONT) begin
                  front_in = front_next;
                  count_in = count_ff - 1'b1;
               end else if (func_ff == FN_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Slot memory: one write or one registered read per executed item.
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         slots[wr_addr] <= value_ff;
      end
      if (cmd.execute && rd_ok_in) begin
         rd_data_ff <= slots[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_push_value;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
      if (cmd.load) begin
         rsp_value_ff  <= rd_ok_ff ? rd_data_ff : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_OUT_W'(count_ff);
         rsp_empty_ff  <= is_empty;
      end
   end

   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words held in a ring buffer.
//
// The req_ channel carries one item: req_func (push front, push back, pop
// front, pop back, peek front, peek back) and req_push_value, used by pushes.
// Every accepted item returns exactly one item on the rsp_ channel: the word
// popped or peeked (zero otherwise), a status (ok, empty, full), the number
// of stored words afterward and an empty flag. Unused function codes do
// nothing and report ok.
// An item passes through capture, one slot memory access with the pointer
// and count update, and a load of the result register, which makes the
// result valid. A new item is taken only once the previous one has been
// loaded, as set by the controller's capture, execute and load sequence.
// A push on a full queue is dropped with the full status; a pop or peek on
// an empty queue reports the empty status and changes nothing.
// Reset clears the front pointer, the count and the result valid flag; no
// memory clearing is needed. When the receiver stalls, the result is held
// in the output register; one further item is still accepted and executed,
// then the block waits until the held result is taken.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
`default_nettype none

module double_ended_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [deq_pkg::FUNC_W-1:0]        req_func,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_push_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [deq_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [deq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [deq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic                                   rsp_is_empty
);
   import deq_pkg::*;

   ctl_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   // A held result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a result is still held");

   // Capture, execute and load never overlap.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.load}))
      else $error("controller issued overlapping commands");

   // An accepted item is executed in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.execute)
      else $error("accepted item was not executed");

endmodule

`default_nettype wire

// ===== test/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: a clocked driver and monitor
// around the block, with a ring-buffer mirror that predicts every reply.
// Depends on deq_pkg and double_ended_queue from the rtl folder.
`default_nettype none

module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   // Function codes 6 and 7 are unused and must behave as no-ops.
   localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam int PHASE_ITEMS = 600;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] value;
      bit                       drain;
   } request_type;

   typedef struct {
      logic [FUNC_W-1:0]           func;
      logic signed [WORD_W-1:0]    word;
      logic [STATUS_W-1:0]         status;
      logic [COUNT_OUT_W-1:0]      count;
      logic                        empty;
   } reply_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [FUNC_W-1:0]           req_func = FN_PUSH_FRONT;
   logic signed [WORD_W-1:0]    req_push_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]    rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_OUT_W-1:0]      rsp_entry_count;
   logic                        rsp_is_empty;

   request_type pending[$];
   reply_type   reply_queue[$];
   int       tx_idle_pct = 35;
   int       rx_idle_pct = 81;
   int       error_count = 0;
   logic     hold_go = 1'b0;
   logic     hold_rx = 1'b0;

   // Mirror of the ring buffer.
   logic signed [WORD_W-1:0] mirror_slot [CAPACITY];
   int mirror_front = 0;
   int mirror_count = 0;

   double_ended_queue DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #5 clock = ~clock;

   function automatic reply_type deque_mirror_step(input logic [FUNC_W-1:0] func,
                                                   input logic signed [WORD_W-1:0] value);
      reply_type r;
      int     pos;
      r.func   = func;
      r.word   = '0;
      r.status = ST_OK;
      case (func)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (mirror_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               if (func == FN_PUSH_FRONT) begin
                  mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
                  mirror_slot[mirror_front] = value;
               end else begin
                  mirror_slot[(mirror_front + mirror_count) % CAPACITY] = value;
               end
               mirror_count++;
            end
         end
         FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (func == FN_POP_FRONT || func == FN_PEEK_FRONT)
                  pos = mirror_front;
               else
                  pos = (mirror_front + mirror_count - 1) % CAPACITY;
               r.word = mirror_slot[pos];
               if (func == FN_POP_FRONT) begin
                  mirror_front = (mirror_front + 1) % CAPACITY;
                  mirror_count--;
               end else if (func == FN_POP_BACK) begin
                  mirror_count--;
               end
            end
         end
         default: ;
      endcase
      r.count = COUNT_OUT_W'(mirror_count);
      r.empty = (mirror_count == 0);
      return r;
   endfunction

   task automatic queue_request(input logic [FUNC_W-1:0] func,
                                input logic signed [WORD_W-1:0] value, input bit drain);
      request_type it;
      it.func  = func;
      it.value = value;
      it.drain = drain;
      pending.push_back(it);
   endtask

   function automatic logic signed [WORD_W-1:0] random_word();
      logic signed [WORD_W-1:0] w;
      case ($urandom_range(19))
         0: w = WORD_MIN;
         1: w = WORD_MAX;
         2: w = '0;
         3: w = -1;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // push_pct steers the fill level so that both full and empty queues recur.
   task automatic queue_random_request(input int push_pct, input bit drain);
      logic [FUNC_W-1:0] func;
      int r;
      r = $urandom_range(99);
      if (r < 3)
         func = $urandom_range(1) ? FN_SPARE_B : FN_SPARE_A;
      else if (r < 15)
         func = $urandom_range(1) ? FN_PEEK_BACK : FN_PEEK_FRONT;
      else if (r < 15 + push_pct * 85 / 100)
         func = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      else
         func = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
      queue_request(func, random_word(), drain);
   endtask

   task automatic queue_random_phase(input int count, input int drain_at);
      int left;
      int push_pct;
      left = 0;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            left = $urandom_range(10, 60);
            case ($urandom_range(2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         left--;
         queue_random_request(push_pct, i == drain_at);
      end
   endtask

   // Driver: the expectation is computed when the item is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            reply_queue.push_back(deque_mirror_step(req_func, req_push_value));
         if (!req_valid || req_ready) begin
            if (pending.size() != 0 && (!pending[0].drain || reply_queue.size() == 0)
                && $urandom_range(99) >= tx_idle_pct) begin
               req_valid      <= 1'b1;
               req_func       <= pending[0].func;
               req_push_value <= pending[0].value;
               pending.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each reply with the oldest expectation.
   always @(posedge clock) begin
      reply_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected reply: word %0d status %0d count %0d empty %0d",
                           rsp_read_value, rsp_status, rsp_entry_count, rsp_is_empty);
            end else begin
               e = reply_queue.pop_front();
               if (rsp_read_value !== e.word || rsp_status !== e.status
                   || rsp_entry_count !== e.count || rsp_is_empty !== e.empty) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("mismatch on func %0d: expected word %0d status %0d count %0d",
                            e.func, e.word, e.status, e.count);
                     $display(" empty %0d, got word %0d status %0d count %0d empty %0d",
                              e.empty, rsp_read_value, rsp_status, rsp_entry_count,
                              rsp_is_empty);
                  end
               end
            end
         end
         rsp_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Long receiver stall so that the block holds a result and blocks its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx <= 1'b0;
   end

   initial begin
      #5ms;
      $display("double_ended_queue verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Requests on an empty queue, and the unused codes.
      queue_request(FN_POP_FRONT, 32'sd5, 1'b0);
      queue_request(FN_POP_BACK, WORD_MAX, 1'b0);
      queue_request(FN_PEEK_FRONT, WORD_MIN, 1'b0);
      queue_request(FN_PEEK_BACK, -1, 1'b0);
      queue_request(FN_SPARE_A, 32'sd7, 1'b0);
      queue_request(FN_SPARE_B, -1, 1'b0);
      // Fill from both ends with the extreme words, then push onto a full queue.
      queue_request(FN_PUSH_FRONT, WORD_MIN, 1'b0);
      queue_request(FN_PUSH_BACK, WORD_MAX, 1'b0);
      queue_request(FN_PUSH_FRONT, '0, 1'b0);
      queue_request(FN_PUSH_BACK, -1, 1'b0);
      for (int i = 0; i < 12; i++)
         queue_request(i % 2 ? FN_PUSH_BACK : FN_PUSH_FRONT, $urandom, 1'b0);
      queue_request(FN_PUSH_BACK, 32'sd1, 1'b0);
      queue_request(FN_PEEK_FRONT, '0, 1'b0);
      queue_request(FN_PEEK_BACK, '0, 1'b0);
      queue_request(FN_POP_FRONT, '0, 1'b0);
      queue_request(FN_POP_BACK, '0, 1'b0);

      queue_random_phase(PHASE_ITEMS, -1);
      while (pending.size() != 0) @(posedge clock);
      tx_idle_pct <= 81;
      rx_idle_pct <= 35;

      queue_random_phase(PHASE_ITEMS, -1);
      while (pending.size() != 0) @(posedge clock);
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;

      // The sender keeps offering during the receiver stall, and partway
      // through it waits until every reply has come back.
      queue_random_phase(PHASE_ITEMS, PHASE_ITEMS / 2);
      hold_go <= 1'b1;

      while (pending.size() != 0 || req_valid || reply_queue.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0)
         $display("double_ended_queue verification clean");
      else
         $display("double_ended_queue verification failed");
      $finish;
   end

endmodule

`default_nettype wire
